// ----- rtl/core/smp_pkg.sv -----
// smp_pkg: shared types and constants for the sorted median select unit
// depends on nothing; used by smp_cell and sorted_median_select_unit
package smp_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     is_final;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] middle_value;
    logic                     run_end;
    logic                     dropped_any;
  } out_word_t;

  // per-cell control from the chain controller
  typedef struct packed {
    logic ins_en;   // a new key goes into the chain this cycle
    logic occ;      // cell holds a live value
    logic left_gt;  // left neighbor is moving right this cycle
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_FIRST,
    ST_SECOND
  } smp_state_t;

endpackage

// ----- rtl/core/smp_cell.sv -----
// smp_cell: one slot of the descending insertion chain
// depends on smp_pkg (cell_ctl_t, DATA_W)
module smp_cell (
  input  logic                              clk,
  input  smp_pkg::cell_ctl_t                ctl,
  input  logic signed [smp_pkg::DATA_W-1:0] key,
  input  logic signed [smp_pkg::DATA_W-1:0] left_val,
  output logic signed [smp_pkg::DATA_W-1:0] val,
  output logic                              gt
);

  logic signed [smp_pkg::DATA_W-1:0] val_r;
  logic signed [smp_pkg::DATA_W-1:0] val_nxt;

  // key lands here or further left when this slot is empty or smaller
  assign gt  = !ctl.occ || (key > val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && gt) begin
      val_nxt = ctl.left_gt ? left_val : key;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- rtl/core/sorted_median_select_unit.sv -----
// sorted_median_select_unit: median of a set of signed values via a
// systolic insertion chain; depends on smp_pkg and smp_cell
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_ready   | smp_pkg::in_word_t
//  out_    | output    | out_valid/out_ready | smp_pkg::out_word_t
//
// one input word per cycle while a set fills; the chain sorts on the fly
// after the final word, one or two result words, one per cycle unless out_
// stalls, read from the middle cells; input waits until the last one is registered
// out_ stalls hold the output register; the chain keeps its contents
// rst_n (synchronous) clears count, overflow flag, state and out_valid;
// cell contents are not reset
module sorted_median_select_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smp_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output smp_pkg::out_word_t  out_word
);

  localparam int unsigned CW = smp_pkg::CNT_W;
  localparam int unsigned IW = smp_pkg::IDX_W;
  localparam int unsigned N  = smp_pkg::MAX_ITEMS;

  smp_pkg::smp_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  smp_pkg::out_word_t  out_word_r, out_word_nxt;

  logic                                 in_acc;
  logic                                 full;
  logic                                 ins_en;
  logic                                 out_free;
  logic [CW-1:0]                        cnt_m1;
  logic [IW-1:0]                        rd_idx;
  logic signed [smp_pkg::DATA_W-1:0]    cell_val [N];
  logic [N-1:0]                         cell_gt;
  smp_pkg::cell_ctl_t                   cell_ctl [N];

  assign in_ready = (state_r == smp_pkg::ST_FILL);
  assign in_acc   = in_valid && in_ready;
  assign full     = (count_r == CW'(N));
  assign ins_en   = in_acc && !full;
  assign out_free = !out_valid_r || out_ready;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_chain
      logic signed [smp_pkg::DATA_W-1:0] left_v;
      assign cell_ctl[i].ins_en  = ins_en;
      assign cell_ctl[i].occ     = (CW'(i) < count_r);
      if (i == 0) begin : g_head
        assign cell_ctl[i].left_gt = 1'b0;
        assign left_v              = in_word.sample;
      end else begin : g_body
        assign cell_ctl[i].left_gt = cell_gt[i-1];
        assign left_v              = cell_val[i-1];
      end
      smp_cell u_cell (
        .clk      (clk),
        .ctl      (cell_ctl[i]),
        .key      (in_word.sample),
        .left_val (left_v),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end
  endgenerate

  // first result sits at (n-1)/2 for both odd and even n, second at n/2
  assign cnt_m1 = count_r - CW'(1);
  always_comb begin
    logic [CW-1:0] idx_full;
    idx_full = (state_r == smp_pkg::ST_SECOND) ? (count_r >> 1) : (cnt_m1 >> 1);
    rd_idx   = idx_full[IW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    case (state_r)
      smp_pkg::ST_FILL: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_word.is_final) begin
            state_nxt = smp_pkg::ST_FIRST;
          end
        end
      end
      smp_pkg::ST_FIRST: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.middle_value = cell_val[rd_idx];
          out_word_nxt.run_end      = count_r[0];
          out_word_nxt.dropped_any  = ovf_r;
          if (count_r[0]) begin
            state_nxt = smp_pkg::ST_FILL;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            state_nxt = smp_pkg::ST_SECOND;
          end
        end
      end
      smp_pkg::ST_SECOND: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.middle_value = cell_val[rd_idx];
          out_word_nxt.run_end      = 1'b1;
          out_word_nxt.dropped_any  = ovf_r;
          state_nxt                 = smp_pkg::ST_FILL;
          count_nxt                 = '0;
          ovf_nxt                   = 1'b0;
        end
      end
      default: begin
        state_nxt = smp_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smp_pkg::ST_FILL;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
